>>> hdl/sliding_median_filter_assert.svh
// ============================================================================
// sliding_median_filter_assert - assertion macros for the median filter
// Concurrent checks clocked on clk and held off while rst_n is low.
// ============================================================================
`ifndef SLIDING_MEDIAN_FILTER_ASSERT_SVH
`define SLIDING_MEDIAN_FILTER_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SMF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smf: same-cycle check failed");
// next-cycle implication
`define SMF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smf: next-cycle check failed");
`else
`define SMF_ASSERT_IMP(lbl, ante, cons)
`define SMF_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> hdl/smf_pkg.sv
// ============================================================================
// smf_pkg - shared types and constants of the sliding median filter
// Register map, controller states and window control bundle.
// ============================================================================
`timescale 1ns / 1ps

package smf_pkg;

  // window_size register
  localparam int          WS_W       = 5;
  localparam logic [4:0]  WS_RESET   = 5'd5;
  localparam int          MIN_WINDOW = 3;

  // config port
  localparam int          CFG_AW     = 3;
  localparam int          CFG_DW     = 32;
  localparam int          CFG_IDX_W  = CFG_AW - 2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = '0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MED,
    ST_SUM,
    ST_DIVGO,
    ST_DIV,
    ST_HOLD
  } smf_state_t;

  typedef struct packed {
    logic wr_en;
    logic rot_left;
    logic rot_right;
  } smf_win_ctrl_t;

endpackage

>>> hdl/smf_in_if.sv
// ============================================================================
// smf_in_if - sample input channel
// valid/ready handshake carrying one signed sample per beat.
// ============================================================================
`timescale 1ns / 1ps

interface smf_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

>>> hdl/smf_out_if.sv
// ============================================================================
// smf_out_if - filtered result channel
// valid/ready handshake carrying the filtered value and the full flag.
// ============================================================================
`timescale 1ns / 1ps

interface smf_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] filtered;
  logic                           window_full;

  modport source (output valid, output filtered, output window_full, input ready);
  modport sink   (input valid, input filtered, input window_full, output ready);
endinterface

>>> hdl/smf_window.sv
// ============================================================================
// smf_window - sample window as a bank of rotating shift registers
// Each entry rotates one bit per cycle while rot_left or rot_right is set;
// the columns at bit 0 and the sign bit are tapped across all entries.
// ============================================================================
`timescale 1ns / 1ps

module smf_window #(
  parameter  int MAX_WINDOW   = 16,
  parameter  int SAMPLE_WIDTH = 16,
  localparam int IDX_W        = $clog2(MAX_WINDOW)
) (
  input  logic                   clk,
  input  smf_pkg::smf_win_ctrl_t ctrl,
  input  logic [IDX_W-1:0]       wr_idx,
  input  logic [SAMPLE_WIDTH-1:0] wr_data,
  output logic [MAX_WINDOW-1:0]  col_lsb,
  output logic [MAX_WINDOW-1:0]  col_msb
);

  logic [SAMPLE_WIDTH-1:0] entry_r [MAX_WINDOW];

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (ctrl.wr_en && (wr_idx == IDX_W'(i))) begin
        entry_r[i] <= wr_data;
      end else if (ctrl.rot_left) begin
        entry_r[i] <= {entry_r[i][SAMPLE_WIDTH-2:0], entry_r[i][SAMPLE_WIDTH-1]};
      end else if (ctrl.rot_right) begin
        entry_r[i] <= {entry_r[i][0], entry_r[i][SAMPLE_WIDTH-1:1]};
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      col_lsb[i] = entry_r[i][0];
      col_msb[i] = entry_r[i][SAMPLE_WIDTH-1];
    end
  end

endmodule

>>> hdl/smf_div.sv
// ============================================================================
// smf_div - serial signed-by-unsigned divider, truncating toward zero
// Restoring division, one quotient bit per cycle over the dividend width.
// ============================================================================
`timescale 1ns / 1ps

module smf_div #(
  parameter int DVD_W = 20,
  parameter int DVS_W = 5,
  parameter int QUO_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [QUO_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             neg_r, neg_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  always_comb begin
    trial    = {rem_r, dvd_r[DVD_W-1]};
    ge       = (trial >= {1'b0, divisor});
    diff     = trial - {1'b0, divisor};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = '0;
      neg_nxt  = dividend[DVD_W-1];
      dvd_nxt  = dividend[DVD_W-1] ? (~dividend + DVD_W'(1)) : dividend;
    end else if (busy_r) begin
      // remainder stays below the divisor, so DVS_W bits hold it
      rem_nxt = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_nxt = {quo_r[QUO_W-2:0], ge};
      dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~quo_r + QUO_W'(1)) : quo_r;

endmodule

>>> hdl/sliding_median_filter.sv
// ============================================================================
// sliding_median_filter - circular-window median, fill-phase mean
// Median: ST_MED walks the bits, then ST_HOLD loads the output register once free.
// Mean (filling): ST_SUM, ST_DIVGO, ST_DIV, ST_HOLD; SUM_W = W+clog2(MAX_WINDOW).
// New samples are taken only in ST_IDLE; the column walk does one bit per cycle.
// Sync active-low reset: window_size=5, pointer and fill count zero, store unknown.
// ============================================================================
`timescale 1ns / 1ps
`include "sliding_median_filter_assert.svh"

module sliding_median_filter #(
  parameter int MAX_WINDOW   = 16,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  smf_in_if.sink                      in_ch,
  smf_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [smf_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [smf_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [smf_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  localparam int IDX_W  = $clog2(MAX_WINDOW);
  localparam int SUM_W  = SAMPLE_WIDTH + $clog2(MAX_WINDOW); // holds any window sum
  localparam int STEP_W = $clog2(SUM_W);
  localparam int ZC_W   = $clog2(MAX_WINDOW + 1);
  localparam int CS_W   = $clog2(2 * MAX_WINDOW + 1);      // column count plus carry
  localparam int WS_W   = smf_pkg::WS_W;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  smf_pkg::smf_state_t state_r, state_nxt;

  logic [WS_W-1:0]         ws_r;
  logic [IDX_W-1:0]        wp_r, wp_nxt;
  logic [WS_W-1:0]         fill_r, fill_nxt;
  logic [WS_W-1:0]         k_r, k_nxt;        // rank still sought among candidates
  logic [MAX_WINDOW-1:0]   sel_r, sel_nxt;    // median candidates / entries summed
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic [CS_W-1:0]         carry_r, carry_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [SAMPLE_WIDTH-1:0] res_r, res_nxt;
  logic                    full_r, full_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [SAMPLE_WIDTH-1:0] out_data_r, out_data_nxt;
  logic                    out_full_r, out_full_nxt;

  // --------------------------------------------------------------------------
  // Datapath helpers
  // --------------------------------------------------------------------------
  logic                    in_fire;
  logic                    slot_free;
  logic [WS_W-1:0]         len_cur;
  logic [WS_W-1:0]         fill_inc;
  logic [MAX_WINDOW-1:0]   len_mask;
  logic [MAX_WINDOW-1:0]   fill_mask;
  logic [MAX_WINDOW-1:0]   col_lsb, col_msb;
  logic [MAX_WINDOW-1:0]   col;
  logic [MAX_WINDOW-1:0]   lo_set;
  logic [ZC_W-1:0]         zeros;
  logic [CS_W-1:0]         colsum;
  logic                    lsb_phase;
  logic                    bitv;
  logic                    div_start;
  logic                    div_done;
  logic [SAMPLE_WIDTH-1:0] div_quo;
  smf_pkg::smf_win_ctrl_t  win_ctrl;

  logic                               cfg_wr;
  logic [smf_pkg::CFG_IDX_W-1:0]      cfg_idx;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid_r || out_ch.ready;

  // lengths above the store depth saturate
  assign len_cur  = (32'(ws_r) > MAX_WINDOW) ? WS_W'(MAX_WINDOW) : ws_r;
  assign fill_inc = (fill_r < len_cur) ? (fill_r + WS_W'(1)) : fill_r;

  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      len_mask[i]  = (32'(len_cur) > 32'(i));
      fill_mask[i] = (32'(fill_inc) > 32'(i));
    end
  end

  // --------------------------------------------------------------------------
  // Config port: single register, user writes only in idle (block does not enforce)
  // --------------------------------------------------------------------------
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[smf_pkg::CFG_AW-1:2];
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_idx == smf_pkg::REG_WINDOW_SIZE) ? smf_pkg::CFG_DW'(ws_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r <= smf_pkg::WS_RESET;
    end else if (cfg_wr && cfg_pready && (cfg_idx == smf_pkg::REG_WINDOW_SIZE)) begin
      ws_r <= cfg_pwdata[WS_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Window store and divider
  // --------------------------------------------------------------------------
  smf_window #(
    .MAX_WINDOW   (MAX_WINDOW),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_window (
    .clk     (clk),
    .ctrl    (win_ctrl),
    .wr_idx  (wp_r),
    .wr_data (in_ch.sample),
    .col_lsb (col_lsb),
    .col_msb (col_msb)
  );

  smf_div #(
    .DVD_W (SUM_W),
    .DVS_W (WS_W),
    .QUO_W (SAMPLE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (fill_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // --------------------------------------------------------------------------
  // Controller
  //   MED : radix select, sign bit first. Each cycle counts candidates whose
  //         current bit puts them in the lower half; the rank k decides which
  //         half survives and what the result bit is.
  //   SUM : bit-serial column sum, LSB first, sign columns repeated for the
  //         extension bits; carry holds the column overflow.
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    k_nxt         = k_r;
    sel_nxt       = sel_r;
    step_nxt      = step_r;
    carry_nxt     = carry_r;
    sum_nxt       = sum_r;
    res_nxt       = res_r;
    full_nxt      = full_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    out_full_nxt  = out_full_r;
    win_ctrl      = '0;
    div_start     = 1'b0;
    lsb_phase     = (32'(step_r) < SAMPLE_WIDTH);
    col           = (state_r == smf_pkg::ST_SUM && lsb_phase) ? col_lsb : col_msb;
    // sign column: a set bit means the smaller value
    lo_set        = (step_r == '0) ? col : ~col;
    zeros         = ZC_W'($countones(sel_r & lo_set));
    colsum        = CS_W'($countones(col & sel_r)) + carry_r;
    bitv          = 1'b0;

    unique case (state_r)
      smf_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (32'(len_cur) < smf_pkg::MIN_WINDOW) begin
            // short window: sample passes through, pointer and fill count untouched
            res_nxt   = in_ch.sample;
            full_nxt  = 1'b0;
            state_nxt = smf_pkg::ST_HOLD;
          end else begin
            win_ctrl.wr_en = 1'b1;
            wp_nxt   = ((32'(wp_r) + 32'd1) >= 32'(len_cur)) ? '0 : (wp_r + IDX_W'(1));
            fill_nxt = fill_inc;
            step_nxt = '0;
            if (fill_inc < len_cur) begin
              sel_nxt   = fill_mask;
              carry_nxt = '0;
              state_nxt = smf_pkg::ST_SUM;
            end else begin
              sel_nxt   = len_mask;
              k_nxt     = len_cur >> 1;
              state_nxt = smf_pkg::ST_MED;
            end
          end
        end
      end

      smf_pkg::ST_MED: begin
        win_ctrl.rot_left = 1'b1;
        if (32'(k_r) < 32'(zeros)) begin
          sel_nxt = sel_r & lo_set;
          bitv    = (step_r == '0);
        end else begin
          k_nxt   = k_r - WS_W'(zeros);
          sel_nxt = sel_r & ~lo_set;
          bitv    = (step_r != '0);
        end
        res_nxt  = {res_r[SAMPLE_WIDTH-2:0], bitv};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(SAMPLE_WIDTH - 1)) begin
          full_nxt  = 1'b1;
          state_nxt = smf_pkg::ST_HOLD;
        end
      end

      smf_pkg::ST_SUM: begin
        win_ctrl.rot_right = lsb_phase;
        sum_nxt   = {colsum[0], sum_r[SUM_W-1:1]};
        carry_nxt = colsum >> 1;
        step_nxt  = step_r + STEP_W'(1);
        if (step_r == STEP_W'(SUM_W - 1)) begin
          state_nxt = smf_pkg::ST_DIVGO;
        end
      end

      smf_pkg::ST_DIVGO: begin
        div_start = 1'b1;
        state_nxt = smf_pkg::ST_DIV;
      end

      smf_pkg::ST_DIV: begin
        if (div_done) begin
          res_nxt   = div_quo;
          full_nxt  = 1'b0;
          state_nxt = smf_pkg::ST_HOLD;
        end
      end

      smf_pkg::ST_HOLD: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          out_full_nxt  = full_r;
          state_nxt     = smf_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = smf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      fill_r      <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    sel_r      <= sel_nxt;
    carry_r    <= carry_nxt;
    sum_r      <= sum_nxt;
    res_r      <= res_nxt;
    full_r     <= full_nxt;
    out_data_r <= out_data_nxt;
    out_full_r <= out_full_nxt;
  end

  assign in_ch.ready        = (state_r == smf_pkg::ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.filtered    = out_data_r;
  assign out_ch.window_full = out_full_r;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  // pointer never leaves the store, even after the length shrinks
  `SMF_ASSERT_IMP(a_wp_in_store, 1'b1, (32'(wp_r) < MAX_WINDOW))
  // the sought rank always lies inside the surviving candidate set
  `SMF_ASSERT_IMP(a_rank_in_set, (state_r == smf_pkg::ST_MED), (32'(k_r) < $countones(sel_r)))
  // mean divisor is never zero
  `SMF_ASSERT_IMP(a_div_nonzero, (state_r == smf_pkg::ST_DIVGO), (fill_r != '0))
  // a result beat appears only out of the hold state
  `SMF_ASSERT_NXT(a_out_from_hold, (state_r != smf_pkg::ST_HOLD) && !out_valid_r, !out_valid_r)

endmodule
